>>> rtl/spfc_pkg.sv
package spfc_pkg;

   localparam int CFG_WIDTH   = 11;
   localparam int COUNT_WIDTH = 32;

   localparam logic [CFG_WIDTH-1:0] ROW_WIDTH_RESET = 11'd1024;

   typedef enum logic [1:0] {
      CLASS_EXTERIOR = 2'd0,
      CLASS_INTERIOR = 2'd1,
      CLASS_OUTLINE  = 2'd2
   } pixel_class_type;

   typedef enum logic [1:0] {
      SIDE_UNKNOWN = 2'd0,
      SIDE_ABOVE   = 2'd1,
      SIDE_BELOW   = 2'd2
   } side_type;

   typedef enum logic [1:0] {
      FETCH_ISSUE,
      FETCH_LOAD,
      FETCH_READY
   } fetch_state_type;

   typedef struct packed {
      logic upper;
      logic middle;
   } entry_type;

   typedef struct packed {
      logic cur;
      logic above;
      logic below;
      logic right;
      logic first_col;
      logic last_col;
      logic has_row;
      logic frame_end;
   } pixel_ctx_type;

endpackage

>>> rtl/spfc_line_mem.sv
module spfc_line_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  spfc_pkg::entry_type       wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output spfc_pkg::entry_type       rd_data
);

   spfc_pkg::entry_type mem [DEPTH];
   spfc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the entry being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/spfc_fetch.sv
module spfc_fetch #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [spfc_pkg::CFG_WIDTH-1:0]      row_width,
   input  logic                                cfg_write,
   input  logic                                accept,
   input  logic                                edge_pixel,
   input  logic                                padding_row,
   output logic                                fetch_ready,
   output spfc_pkg::pixel_ctx_type             ctx,
   output logic                                mem_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]        mem_wr_addr,
   output spfc_pkg::entry_type                 mem_wr_data,
   output logic [$clog2(MAX_WIDTH)-1:0]        mem_rd_addr,
   input  spfc_pkg::entry_type                 mem_rd_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = (AW + 1 > spfc_pkg::CFG_WIDTH) ? AW + 1 : spfc_pkg::CFG_WIDTH;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);

   spfc_pkg::fetch_state_type state_ff, state_in;
   logic [AW-1:0]             col_ff, col_in;
   logic [1:0]                rows_ff, rows_in;
   spfc_pkg::entry_type       cur_ff, cur_in;
   spfc_pkg::entry_type       row0_ff, row0_in;
   spfc_pkg::entry_type       row1_ff, row1_in;
   logic                      saved_ff, saved_in;

   logic [CW-1:0]       width_ext;
   logic [CW-1:0]       eff_w;
   logic [AW-1:0]       last_idx;
   logic [AW-1:0]       c;
   logic [AW-1:0]       next_col;
   logic                last_col;
   logic                pix;
   logic                right;
   spfc_pkg::entry_type wdata;

   always_comb begin
      width_ext = CW'(row_width);
      priority if (width_ext == '0) begin
         eff_w = CW'(1);
      end else if (width_ext > MAX_W) begin
         eff_w = MAX_W;
      end else begin
         eff_w = width_ext;
      end
      last_idx = AW'(eff_w - CW'(1));
      c        = (CW'(col_ff) >= eff_w) ? last_idx : col_ff;
      last_col = (c == last_idx);
      next_col = last_col ? '0 : c + AW'(1);
      pix      = edge_pixel & ~padding_row;
      right    = saved_ff ? row1_ff.middle : mem_rd_data.middle;
      wdata.upper  = cur_ff.middle;
      wdata.middle = pix;
   end

   always_comb begin
      ctx.cur       = cur_ff.middle;
      ctx.above     = (rows_ff >= 2'd2) ? cur_ff.upper : 1'b0;
      ctx.below     = pix;
      ctx.right     = right;
      ctx.first_col = (c == '0);
      ctx.last_col  = last_col;
      ctx.has_row   = (rows_ff != 2'd0);
      ctx.frame_end = padding_row & last_col;
   end

   assign mem_wr_en   = accept;
   assign mem_wr_addr = c;
   assign mem_wr_data = wdata;

   always_comb begin
      state_in = state_ff;
      priority if (cfg_write) begin
         state_in = spfc_pkg::FETCH_ISSUE;
      end else begin
         unique case (state_ff)
            spfc_pkg::FETCH_ISSUE: state_in = spfc_pkg::FETCH_LOAD;
            spfc_pkg::FETCH_LOAD:  state_in = spfc_pkg::FETCH_READY;
            spfc_pkg::FETCH_READY: state_in = spfc_pkg::FETCH_READY;
            default:               state_in = spfc_pkg::FETCH_READY;
         endcase
      end
   end

   always_comb begin
      fetch_ready = 1'b0;
      unique case (state_ff)
         spfc_pkg::FETCH_ISSUE: begin
            mem_rd_addr = c;
         end
         spfc_pkg::FETCH_LOAD: begin
            mem_rd_addr = c + AW'(1);
         end
         spfc_pkg::FETCH_READY: begin
            fetch_ready = 1'b1;
            mem_rd_addr = accept ? next_col + AW'(1) : c + AW'(1);
         end
         default: begin
            mem_rd_addr = c + AW'(1);
         end
      endcase
   end

   always_comb begin
      col_in   = col_ff;
      rows_in  = rows_ff;
      cur_in   = cur_ff;
      row0_in  = row0_ff;
      row1_in  = row1_ff;
      saved_in = saved_ff;
      if (state_ff == spfc_pkg::FETCH_LOAD) begin
         cur_in   = mem_rd_data;
         saved_in = 1'b0;
      end
      if (accept) begin
         col_in   = next_col;
         saved_in = last_col;
         if (last_col) begin
            cur_in = (c == '0) ? wdata : row0_ff;
         end else begin
            cur_in = saved_ff ? row1_ff : mem_rd_data;
         end
         if (c == '0) begin
            row0_in = wdata;
         end
         if (c == AW'(1)) begin
            row1_in = wdata;
         end
         if (last_col) begin
            if (padding_row) begin
               rows_in = 2'd0;
            end else if (rows_ff < 2'd2) begin
               rows_in = rows_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spfc_pkg::FETCH_READY;
         col_ff   <= '0;
         rows_ff  <= 2'd0;
         saved_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         rows_ff  <= rows_in;
         saved_ff <= saved_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      row0_ff <= row0_in;
      row1_ff <= row1_in;
   end

   a_accept_when_loaded: assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == spfc_pkg::FETCH_READY)
      else $error("Request accepted while the line window was reloading.");

   a_cfg_reloads: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> state_ff == spfc_pkg::FETCH_ISSUE)
      else $error("Width write did not restart the line window fetch.");

endmodule

>>> rtl/spfc_classify.sv
module spfc_classify (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  spfc_pkg::pixel_ctx_type              ctx,
   output logic                                 out_free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_pixel_class,
   output logic [spfc_pkg::COUNT_WIDTH-1:0]     rsp_filled_count,
   output logic                                 rsp_shape_error,
   output logic                                 rsp_frame_done
);

   logic                              inside_ff, inside_in;
   spfc_pkg::side_type                side_ff, side_in;
   logic [spfc_pkg::COUNT_WIDTH-1:0]  fill_ff, fill_in;
   logic                              error_ff, error_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   spfc_pkg::pixel_class_type         rsp_class_ff;
   logic [spfc_pkg::COUNT_WIDTH-1:0]  rsp_count_ff;
   logic                              rsp_error_ff;
   logic                              rsp_done_ff;

   logic                              ins0;
   spfc_pkg::side_type                side0;
   spfc_pkg::side_type                end_side;
   spfc_pkg::side_type                side_new;
   spfc_pkg::pixel_class_type         cls;
   logic                              touch_both;
   logic                              toggle;
   logic                              err_now;
   logic                              filled;
   logic [spfc_pkg::COUNT_WIDTH-1:0]  fill_next;
   logic                              err_next;
   logic                              emit;

   always_comb begin
      ins0       = ctx.first_col ? 1'b0 : inside_ff;
      side0      = ctx.first_col ? spfc_pkg::SIDE_UNKNOWN : side_ff;
      touch_both = ctx.above & ctx.below;
      priority if (ctx.above) begin
         end_side = spfc_pkg::SIDE_ABOVE;
      end else if (ctx.below) begin
         end_side = spfc_pkg::SIDE_BELOW;
      end else begin
         end_side = spfc_pkg::SIDE_UNKNOWN;
      end
      toggle   = 1'b0;
      err_now  = 1'b0;
      side_new = side0;
      if (!ctx.cur) begin
         cls      = ins0 ? spfc_pkg::CLASS_INTERIOR : spfc_pkg::CLASS_EXTERIOR;
         filled   = ins0;
         side_new = spfc_pkg::SIDE_UNKNOWN;
      end else begin
         cls    = spfc_pkg::CLASS_OUTLINE;
         filled = 1'b1;
         if (side0 == spfc_pkg::SIDE_UNKNOWN) begin
            if (ctx.last_col || !ctx.right) begin
               toggle = 1'b1;
            end else begin
               side_new = end_side;
               err_now  = touch_both;
            end
         end else if (!ctx.last_col && !ctx.right) begin
            toggle   = (end_side != side0);
            err_now  = touch_both;
            side_new = spfc_pkg::SIDE_UNKNOWN;
         end
      end
      fill_next = (filled && (fill_ff != '1)) ? fill_ff + spfc_pkg::COUNT_WIDTH'(1) : fill_ff;
      err_next  = error_ff | err_now;
      emit      = accept & ctx.has_row;
   end

   always_comb begin
      inside_in = inside_ff;
      side_in   = side_ff;
      fill_in   = fill_ff;
      error_in  = error_ff;
      if (emit) begin
         inside_in = ins0 ^ toggle;
         side_in   = side_new;
         fill_in   = fill_next;
         error_in  = err_next;
      end
      if (accept && ctx.frame_end) begin
         inside_in = 1'b0;
         side_in   = spfc_pkg::SIDE_UNKNOWN;
         fill_in   = '0;
         error_in  = 1'b0;
      end
   end

   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         side_ff      <= spfc_pkg::SIDE_UNKNOWN;
         fill_ff      <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inside_ff    <= inside_in;
         side_ff      <= side_in;
         fill_ff      <= fill_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_class_ff <= cls;
         rsp_count_ff <= fill_next;
         rsp_error_ff <= err_next;
         rsp_done_ff  <= ctx.frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_class  = rsp_class_ff;
   assign rsp_filled_count = rsp_count_ff;
   assign rsp_shape_error  = rsp_error_ff;
   assign rsp_frame_done   = rsp_done_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("Result produced while the output register was still full.");

   a_outline_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff == spfc_pkg::CLASS_OUTLINE |-> rsp_count_ff != '0)
      else $error("Outline pixel reported with a zero fill count.");

endmodule

>>> rtl/scanline_parity_fill_counter_top.sv
// Chan  Dir  Handshake    Payload
// req   in   valid/ready  req_edge_pixel, req_padding_row
// rsp   out  valid/ready  rsp_pixel_class, rsp_filled_count, rsp_shape_error, rsp_frame_done
// csr   in   valid/ready  csr_row_width
//
// One request is taken per cycle unless stalled; results leave from the output register.
// The line memory is read one column ahead, so the window for the next pixel is ready in time.
// A row width write reloads that window; req_ready stays low in the ISSUE and LOAD states.
// Reset is synchronous; the line memory is not cleared and rows are rebuilt as they arrive.
// A stalled result blocks new requests only when it is not taken in the same cycle.
module scanline_parity_fill_counter_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_edge_pixel,
   input  logic                                 req_padding_row,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_pixel_class,
   output logic [spfc_pkg::COUNT_WIDTH-1:0]     rsp_filled_count,
   output logic                                 rsp_shape_error,
   output logic                                 rsp_frame_done,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [spfc_pkg::CFG_WIDTH-1:0]       csr_row_width
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [spfc_pkg::CFG_WIDTH-1:0] row_width_ff, row_width_in;
   logic                           cfg_write;
   logic                           accept;
   logic                           fetch_ready;
   logic                           out_free;
   spfc_pkg::pixel_ctx_type        ctx;
   logic                           mem_wr_en;
   logic [AW-1:0]                  mem_wr_addr;
   spfc_pkg::entry_type            mem_wr_data;
   logic [AW-1:0]                  mem_rd_addr;
   spfc_pkg::entry_type            mem_rd_data;

   assign csr_ready    = 1'b1;
   assign cfg_write    = csr_valid & csr_ready;
   assign row_width_in = cfg_write ? csr_row_width : row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= spfc_pkg::ROW_WIDTH_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   assign req_ready = fetch_ready & out_free;
   assign accept    = req_valid & req_ready;

   spfc_fetch #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_fetch (
      .clock       (clock),
      .reset       (reset),
      .row_width   (row_width_ff),
      .cfg_write   (cfg_write),
      .accept      (accept),
      .edge_pixel  (req_edge_pixel),
      .padding_row (req_padding_row),
      .fetch_ready (fetch_ready),
      .ctx         (ctx),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   spfc_line_mem #(
      .DEPTH(MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   spfc_classify u_classify (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .ctx              (ctx),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_class  (rsp_pixel_class),
      .rsp_filled_count (rsp_filled_count),
      .rsp_shape_error  (rsp_shape_error),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

>>> bench/scanline_fill_checker.sv
module scanline_fill_checker #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_edge_pixel,
   input  logic                               req_padding_row,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [1:0]                         rsp_pixel_class,
   input  logic [spfc_pkg::COUNT_WIDTH-1:0]   rsp_filled_count,
   input  logic                               rsp_shape_error,
   input  logic                               rsp_frame_done,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [spfc_pkg::CFG_WIDTH-1:0]     csr_row_width,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      spfc_pkg::pixel_class_type        cls;
      logic [spfc_pkg::COUNT_WIDTH-1:0] count;
      logic                             shape_err;
      logic                             done;
   } pixel_result_type;

   logic                             upper_row [MAX_WIDTH];
   logic                             middle_row [MAX_WIDTH];
   logic [spfc_pkg::CFG_WIDTH-1:0]   width_reg;
   int                               col_pos;
   int                               rows_held;
   logic                             fill_on;
   logic                             shape_err;
   spfc_pkg::side_type               entry_side;
   logic [spfc_pkg::COUNT_WIDTH-1:0] fill_total;
   pixel_result_type                 expected_q [$];
   int                               reports;

   function automatic void clear_frame();
      col_pos = 0;
      rows_held = 0;
      fill_on = 1'b0;
      entry_side = spfc_pkg::SIDE_UNKNOWN;
      fill_total = '0;
      shape_err = 1'b0;
   endfunction

   function automatic spfc_pkg::side_type run_side(logic above, logic below);
      if (above && below) begin
         shape_err = 1'b1;
         return spfc_pkg::SIDE_ABOVE;
      end
      if (above) return spfc_pkg::SIDE_ABOVE;
      if (below) return spfc_pkg::SIDE_BELOW;
      return spfc_pkg::SIDE_UNKNOWN;
   endfunction

   function automatic void bump_fill();
      if (fill_total != '1) fill_total = fill_total + spfc_pkg::COUNT_WIDTH'(1);
   endfunction

   task automatic classify_pixel(input logic edge_in, input logic pad_in);
      int                 w;
      int                 c;
      logic               pix;
      logic               last;
      logic               cur;
      logic               above;
      logic               below;
      logic               right;
      spfc_pkg::side_type side_now;
      pixel_result_type   res;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      c = col_pos;
      if (c >= w) c = w - 1;
      last = (c + 1 >= w);
      pix = pad_in ? 1'b0 : edge_in;
      if (rows_held >= 1) begin
         cur = middle_row[c];
         above = (rows_held >= 2) ? upper_row[c] : 1'b0;
         below = pix;
         right = last ? 1'b0 : middle_row[c + 1];
         if (c == 0) begin
            fill_on = 1'b0;
            entry_side = spfc_pkg::SIDE_UNKNOWN;
         end
         if (!cur) begin
            res.cls = fill_on ? spfc_pkg::CLASS_INTERIOR : spfc_pkg::CLASS_EXTERIOR;
            if (fill_on) bump_fill();
            entry_side = spfc_pkg::SIDE_UNKNOWN;
         end else begin
            res.cls = spfc_pkg::CLASS_OUTLINE;
            bump_fill();
            if (entry_side == spfc_pkg::SIDE_UNKNOWN) begin
               if (last || !right) fill_on = !fill_on;
               else entry_side = run_side(above, below);
            end else if (!last && !right) begin
               side_now = run_side(above, below);
               if (side_now != entry_side) fill_on = !fill_on;
               entry_side = spfc_pkg::SIDE_UNKNOWN;
            end
         end
         res.count = fill_total;
         res.shape_err = shape_err;
         res.done = pad_in && last;
         expected_q = {expected_q, res};
      end
      upper_row[c] = middle_row[c];
      middle_row[c] = pix;
      if (last) begin
         if (pad_in) begin
            clear_frame();
         end else begin
            col_pos = 0;
            if (rows_held < 2) rows_held++;
         end
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         width_reg = spfc_pkg::ROW_WIDTH_RESET;
         clear_frame();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (reports < 10) begin
                  reports++;
                  $display("checker: result %0d arrived with nothing expected", checked);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_pixel_class !== want.cls || rsp_filled_count !== want.count ||
                   rsp_shape_error !== want.shape_err || rsp_frame_done !== want.done) begin
                  fail_count++;
                  if (reports < 10) begin
                     reports++;
                     $display("checker: result %0d expected class %0d count %0d error %0b done %0b",
                              checked, want.cls, want.count, want.shape_err, want.done);
                     $display("checker: result %0d got      class %0d count %0d error %0b done %0b",
                              checked, rsp_pixel_class, rsp_filled_count, rsp_shape_error,
                              rsp_frame_done);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) width_reg = csr_row_width;
         if (req_valid && req_ready) classify_pixel(req_edge_pixel, req_padding_row);
      end
      pending <= expected_q.size();
   end

endmodule

>>> bench/scanline_parity_fill_counter_top_tb.sv
module scanline_parity_fill_counter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  MAX_WIDTH    = 1024;
   localparam int  CYCLE_LIMIT  = 300000;
   localparam int  HOLD_CYCLES  = 200;
   localparam int  SETTLE       = 6;
   localparam byte OUTLINE_CHAR = "#";

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_edge_pixel = 1'b0;
   logic                             req_padding_row = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [1:0]                       rsp_pixel_class;
   logic [spfc_pkg::COUNT_WIDTH-1:0] rsp_filled_count;
   logic                             rsp_shape_error;
   logic                             rsp_frame_done;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [spfc_pkg::CFG_WIDTH-1:0]   csr_row_width = '0;

   int                               fail_count;
   int                               pending;
   int                               checked;
   int                               idle_pct = 0;
   int                               stall_pct = 0;
   int                               hold_asked = 0;
   int                               hold_taken = 0;
   int                               hold_left = 0;
   int                               cycles = 0;
   int                               tb_col = 0;
   int                               tb_rows = 0;
   logic [spfc_pkg::CFG_WIDTH-1:0]   tb_width = spfc_pkg::ROW_WIDTH_RESET;
   int                               request_count = 0;
   int                               frame_count = 0;
   int                               width_writes = 0;
   bit                               art [16][MAX_WIDTH];

   scanline_parity_fill_counter_top #(
      .MAX_WIDTH(MAX_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_edge_pixel(req_edge_pixel),
      .req_padding_row(req_padding_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_class(rsp_pixel_class),
      .rsp_filled_count(rsp_filled_count),
      .rsp_shape_error(rsp_shape_error),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_row_width(csr_row_width)
   );

   scanline_fill_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) fill_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_edge_pixel(req_edge_pixel),
      .req_padding_row(req_padding_row),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_class(rsp_pixel_class),
      .rsp_filled_count(rsp_filled_count),
      .rsp_shape_error(rsp_shape_error),
      .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_row_width(csr_row_width),
      .fail_count(fail_count),
      .pending(pending),
      .checked(checked)
   );

   always #6ns clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The long hold is counted here so that the request side keeps pushing meanwhile.
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic int eff_width();
      int w;
      w = int'(tb_width);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   task automatic put_pixel(input logic edge_in, input logic pad_in);
      int w;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_edge_pixel <= 1'($urandom_range(1));
         req_padding_row <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_edge_pixel <= edge_in;
      req_padding_row <= pad_in;
      do @(posedge clock); while (!req_ready);
      request_count++;
      w = eff_width();
      if (tb_col >= w) tb_col = w - 1;
      if (tb_col + 1 >= w) begin
         tb_col = 0;
         if (pad_in) begin
            tb_rows = 0;
            frame_count++;
         end else if (tb_rows < 2) begin
            tb_rows++;
         end
      end else begin
         tb_col++;
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_width(input logic [spfc_pkg::CFG_WIDTH-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_row_width <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tb_width = value;
      width_writes++;
   endtask

   task automatic send_art(input string line, input logic pad_in);
      int i;
      for (i = 0; i < line.len(); i++) put_pixel(line[i] == OUTLINE_CHAR, pad_in);
   endtask

   // Rectangle outlines, possibly overlapping, give runs that leave on the same or the
   // opposite side as well as runs touching both sides.
   task automatic draw_frame(input int rows, input bit noisy);
      int w;
      int r;
      int c;
      int r0;
      int r1;
      int c0;
      int c1;
      w = eff_width();
      for (r = 0; r < rows; r++)
         for (c = 0; c < w; c++) art[r][c] = noisy ? ($urandom_range(99) < 35) : 1'b0;
      repeat ($urandom_range(1, 3)) begin
         r0 = $urandom_range(0, rows - 1);
         r1 = $urandom_range(r0, rows - 1);
         c0 = $urandom_range(0, w - 1);
         c1 = $urandom_range(c0, w - 1);
         for (r = r0; r <= r1; r++) begin
            art[r][c0] = 1'b1;
            art[r][c1] = 1'b1;
         end
         for (c = c0; c <= c1; c++) begin
            art[r0][c] = 1'b1;
            art[r1][c] = 1'b1;
         end
      end
   endtask

   task automatic send_row(input int r, input bit pad_noise);
      int c;
      do begin
         c = (tb_col < eff_width()) ? tb_col : eff_width() - 1;
         put_pixel(art[r][c], pad_noise && ($urandom_range(11) == 0));
      end while (tb_col != 0);
   endtask

   task automatic close_frame();
      while (tb_rows != 0 || tb_col != 0) put_pixel(1'($urandom_range(1)), 1'b1);
   endtask

   task automatic empty_frame();
      do put_pixel(1'($urandom_range(1)), 1'b1); while (tb_col != 0);
   endtask

   task automatic send_frame(input int rows, input bit noisy, input bit pad_noise);
      int r;
      draw_frame(rows, noisy);
      for (r = 0; r < rows; r++) send_row(r, pad_noise);
      close_frame();
   endtask

   // A wide row is started and then cut short by a narrower width.
   task automatic cut_wide_row(input int n, input logic [spfc_pkg::CFG_WIDTH-1:0] narrow);
      repeat (n) put_pixel(1'($urandom_range(1)), 1'b0);
      write_width(narrow);
      close_frame();
   endtask

   task automatic lower_mid_frame();
      int w;
      int r;
      int j;
      int k;
      int more;
      w = eff_width();
      if (w >= 2) begin
         r = $urandom_range(1, 3);
         draw_frame(r + 1, 1'b0);
         for (j = 0; j < r; j++) send_row(j, 1'b0);
         k = $urandom_range(1, w - 1);
         for (j = 0; j < k; j++) put_pixel(art[r][j], 1'b0);
         write_width(spfc_pkg::CFG_WIDTH'($urandom_range(0, w - 1)));
         more = $urandom_range(1, 3);
         draw_frame(more, 1'($urandom_range(1)));
         for (j = 0; j < more; j++) send_row(j, 1'b0);
         close_frame();
      end
   endtask

   function automatic logic [spfc_pkg::CFG_WIDTH-1:0] pick_width();
      case ($urandom_range(15))
         0: return '0;
         1: return 11'd1;
         2: return 11'd2;
         default: return spfc_pkg::CFG_WIDTH'($urandom_range(3, 24));
      endcase
   endfunction

   task automatic random_phase(input int goal, input int idle, input int stall, input bit hold);
      int start;
      idle_pct = idle;
      stall_pct = stall;
      start = request_count;
      if (hold) hold_asked++;
      while (request_count - start < goal) begin
         case ($urandom_range(19))
            0: empty_frame();
            1, 2: lower_mid_frame();
            3, 4: write_width(pick_width());
            5, 6, 7: send_frame($urandom_range(1, 6), 1'b1, 1'b1);
            default: send_frame($urandom_range(1, 6), 1'b0, 1'b0);
         endcase
      end
      close_frame();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      cut_wide_row(12, 11'd3);
      send_frame(2, 1'b0, 1'b0);

      write_width('0);
      send_art("#", 1'b0);
      send_art("#", 1'b0);
      send_art(".", 1'b0);
      send_art("#", 1'b1);

      write_width(11'd4);
      send_art("#.#.", 1'b1);
      send_art("###.", 1'b0);
      send_art("####", 1'b0);
      send_art("#.#.", 1'b0);
      send_art(".##.", 1'b0);
      send_art("#..#", 1'b1);

      write_width('1);
      cut_wide_row(40, 11'd5);

      random_phase(300, 0, 0, 1'b1);
      random_phase(300, 67, 0, 1'b0);
      random_phase(300, 0, 67, 1'b1);
      random_phase(300, 36, 36, 1'b0);

      wait_idle();
      $display("tb: %0d pixel requests in %0d frames, %0d results checked, %0d row width writes",
               request_count, frame_count, checked, width_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> scanline_parity_fill_counter_top.f
rtl/spfc_pkg.sv
rtl/spfc_line_mem.sv
rtl/spfc_fetch.sv
rtl/spfc_classify.sv
rtl/scanline_parity_fill_counter_top.sv
bench/scanline_fill_checker.sv
bench/scanline_parity_fill_counter_top_tb.sv
